// ===== rtl/core/linear_policy_action_select_defines.svh =====
// Assertion macros for the linear policy action selector.
// Used by the top level; compiled out when SYNTHESIS is defined.
`ifndef LINEAR_POLICY_ACTION_SELECT_DEFINES_SVH
`define LINEAR_POLICY_ACTION_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
`define LPAS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lpas assertion failed");
`define LPAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpas assertion failed");
`else
`define LPAS_ASSERT(label, clk, rst_n, prop)
`define LPAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lpas_pkg.sv =====
// Shared types and constants of the linear policy action selector.
// No dependencies.
`default_nettype none
package lpas_pkg;

  localparam int MAX_FEATURES = 32;
  localparam int MAX_ACTIONS  = 8;
  localparam int VALUE_BITS   = 16;
  localparam int STORE_DEPTH  = MAX_FEATURES * MAX_ACTIONS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int FEAT_W       = 6;
  localparam int ACT_CNT_W    = 4;
  localparam int ACT_W        = $clog2(MAX_ACTIONS);
  localparam int SCORE_W      = 40;
  localparam int PROD_W       = 2 * VALUE_BITS;
  localparam int LFSR_W       = 32;
  localparam int TIE_PROD_W   = LFSR_W + ACT_CNT_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 40;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'hA300_0000;
  localparam logic [FEAT_W-1:0] FEAT_RESET = FEAT_W'(MAX_FEATURES);
  localparam logic [ACT_CNT_W-1:0] ACT_RESET = ACT_CNT_W'(MAX_ACTIONS);

  typedef enum logic {
    CMD_LOAD_WEIGHT = 1'b0,
    CMD_FEATURE     = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEATURE_COUNT = 2'd0,
    CFG_ACTION_COUNT  = 2'd1,
    CFG_TIE_THRESHOLD = 2'd2,
    CFG_RANDOM_SEED   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SEL_INIT,
    ST_SEL_STEP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cmd_e                   command;
    logic [ADDR_W-1:0]      weight_index;
    logic [VALUE_BITS-1:0]  sample_value;
    logic                   last_feature;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]   chosen_action;
    logic [SCORE_W-1:0] chosen_score;
  } out_item_t;

  typedef struct packed {
    logic weight_we;
    logic accept_feature;
    logic mac_issue;
    logic pos_inc;
    logic sel_init;
    logic sel_step;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic in_is_feature;
    logic in_last;
    logic accum_ok;
    logic item_last;
    logic issue_done;
    logic pipe_empty;
    logic sel_done;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lpas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lpas_ctrl.sv =====
// Sequencer of the linear policy action selector: input handshake, MAC and selection passes.
// Depends on lpas_pkg.
`default_nettype none
module lpas_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lpas_pkg::dp_status_t status_i,
  output lpas_pkg::dp_cmd_t        cmd_o
);
  import lpas_pkg::*;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && status_i.in_is_feature) begin
          if (status_i.accum_ok) begin
            state_d = ST_MAC;
          end else if (status_i.in_last) begin
            state_d = ST_SEL_INIT;
          end
        end
      end
      ST_MAC: begin
        if (status_i.issue_done && status_i.pipe_empty) begin
          state_d = status_i.item_last ? ST_SEL_INIT : ST_IDLE;
        end
      end
      ST_SEL_INIT: state_d = ST_SEL_STEP;
      ST_SEL_STEP: begin
        if (status_i.sel_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cmd_o = '0;
    cmd_o.weight_we      = in_fire && !status_i.in_is_feature;
    cmd_o.accept_feature = in_fire && status_i.in_is_feature;
    case (state_q)
      ST_MAC: begin
        cmd_o.mac_issue = !status_i.issue_done;
        cmd_o.pos_inc   = status_i.issue_done && status_i.pipe_empty;
      end
      ST_SEL_INIT: cmd_o.sel_init = 1'b1;
      ST_SEL_STEP: cmd_o.sel_step = !status_i.sel_done;
      ST_EMIT:     cmd_o.emit = status_i.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/lpas_datapath.sv =====
// Datapath: config registers, weight RAM, MAC pipeline, scores, tie-break LFSR, output register.
// Depends on lpas_pkg and lpas_ram.
`default_nettype none
module lpas_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [lpas_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [lpas_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire lpas_pkg::in_item_t                in_data_i,
  input  wire lpas_pkg::dp_cmd_t                 cmd_i,
  output lpas_pkg::dp_status_t                   status_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output lpas_pkg::out_item_t                    out_data_o
);
  import lpas_pkg::*;

  logic [FEAT_W-1:0]    fc_q;
  logic [ACT_CNT_W-1:0] ac_q;
  logic [SCORE_W-1:0]   thr_q;
  logic [LFSR_W-1:0]    lfsr_q;
  logic [FEAT_W-1:0]    nf_eff;
  logic [ACT_CNT_W-1:0] na_eff;

  logic [FEAT_W-1:0]    pos_q;
  logic signed [VALUE_BITS-1:0] value_q;
  logic                 last_q;
  logic [ACT_CNT_W-1:0] cnt_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [VALUE_BITS-1:0] rdata;
  logic                 v1_q, v2_q;
  logic [ACT_W-1:0]     a1_q, a2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SCORE_W-1:0] score_q [MAX_ACTIONS];
  logic signed [SCORE_W:0]   sum;
  logic signed [SCORE_W-1:0] sat;

  logic [ACT_W-1:0]     best_q;
  logic signed [SCORE_W-1:0] best_val_q;
  logic [ACT_W-1:0]     ties_q;
  logic [ACT_CNT_W-1:0] sel_idx_q;
  logic signed [SCORE_W-1:0] cur;
  logic signed [SCORE_W:0]   diff;
  logic [SCORE_W:0]     gap;
  logic                 tie;
  logic [LFSR_W-1:0]    lfsr_nx;
  logic [ACT_CNT_W-1:0] factor;
  logic [TIE_PROD_W-1:0] draw;
  logic                 take;

  logic                 out_valid_q;
  out_item_t            out_q;

  always_comb begin
    if (fc_q == '0) begin
      nf_eff = FEAT_W'(1);
    end else if (fc_q > FEAT_RESET) begin
      nf_eff = FEAT_RESET;
    end else begin
      nf_eff = fc_q;
    end
    if (ac_q == '0) begin
      na_eff = ACT_CNT_W'(1);
    end else if (ac_q > ACT_RESET) begin
      na_eff = ACT_RESET;
    end else begin
      na_eff = ac_q;
    end
  end

  lpas_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.weight_we),
    .waddr_i(in_data_i.weight_index),
    .wdata_i(in_data_i.sample_value),
    .re_i   (cmd_i.mac_issue),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  // saturating accumulate
  always_comb begin
    sum = {score_q[a2_q][SCORE_W-1], score_q[a2_q]}
        + {{(SCORE_W + 1 - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      sat = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      sat = sum[SCORE_W-1:0];
    end
  end

  // tie-break compare and draw
  always_comb begin
    cur     = score_q[sel_idx_q[ACT_W-1:0]];
    diff    = {cur[SCORE_W-1], cur} - {best_val_q[SCORE_W-1], best_val_q};
    gap     = diff[SCORE_W] ? 41'(-diff) : 41'(diff);
    tie     = gap < {1'b0, thr_q};
    lfsr_nx = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);
    factor  = {1'b0, ties_q} + ACT_CNT_W'(2);
    draw    = TIE_PROD_W'(lfsr_nx) * TIE_PROD_W'(factor);
    take    = (draw[TIE_PROD_W-1:LFSR_W] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q        <= FEAT_RESET;
      ac_q        <= ACT_RESET;
      thr_q       <= SCORE_W'(1);
      lfsr_q      <= LFSR_W'(1);
      pos_q       <= '0;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      sel_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FEATURE_COUNT: fc_q   <= cfg_data_i[FEAT_W-1:0];
          CFG_ACTION_COUNT:  ac_q   <= cfg_data_i[ACT_CNT_W-1:0];
          CFG_TIE_THRESHOLD: thr_q  <= cfg_data_i[SCORE_W-1:0];
          CFG_RANDOM_SEED:   lfsr_q <= cfg_data_i[LFSR_W-1:0];
          default: ;
        endcase
      end else if (cmd_i.sel_step && tie) begin
        lfsr_q <= lfsr_nx;
      end
      if (cmd_i.accept_feature) begin
        cnt_q <= '0;
      end else if (cmd_i.mac_issue) begin
        cnt_q <= cnt_q + ACT_CNT_W'(1);
      end
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
      if (cmd_i.emit) begin
        pos_q <= '0;
      end else if (cmd_i.pos_inc) begin
        pos_q <= pos_q + FEAT_W'(1);
      end
      if (cmd_i.sel_init) begin
        sel_idx_q <= ACT_CNT_W'(1);
      end else if (cmd_i.sel_step) begin
        sel_idx_q <= sel_idx_q + ACT_CNT_W'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_feature) begin
      value_q <= in_data_i.sample_value;
      last_q  <= in_data_i.last_feature;
      addr_q  <= ADDR_W'(pos_q);
    end else if (cmd_i.mac_issue) begin
      addr_q <= addr_q + ADDR_W'(nf_eff);
    end
    a1_q   <= cnt_q[ACT_W-1:0];
    a2_q   <= a1_q;
    prod_q <= value_q * $signed(rdata);
    if (cmd_i.accept_feature && (pos_q == '0)) begin
      for (int i = 0; i < MAX_ACTIONS; i++) begin
        score_q[i] <= '0;
      end
    end else if (v2_q) begin
      score_q[a2_q] <= sat;
    end
    if (cmd_i.sel_init) begin
      best_q     <= '0;
      best_val_q <= score_q[0];
      ties_q     <= '0;
    end else if (cmd_i.sel_step) begin
      if (tie) begin
        ties_q <= ties_q + ACT_W'(1);
        if (take) begin
          best_q     <= sel_idx_q[ACT_W-1:0];
          best_val_q <= cur;
        end
      end else if (cur > best_val_q) begin
        best_q     <= sel_idx_q[ACT_W-1:0];
        best_val_q <= cur;
        ties_q     <= '0;
      end
    end
    if (cmd_i.emit) begin
      out_q.chosen_action <= best_q;
      out_q.chosen_score  <= best_val_q;
    end
  end

  always_comb begin
    status_o.in_is_feature = (in_data_i.command == CMD_FEATURE);
    status_o.in_last       = in_data_i.last_feature;
    status_o.accum_ok      = pos_q < nf_eff;
    status_o.item_last     = last_q;
    status_o.issue_done    = (cnt_q == na_eff);
    status_o.pipe_empty    = !v1_q && !v2_q;
    status_o.sel_done      = (sel_idx_q == na_eff);
    status_o.out_free      = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/core/linear_policy_action_select.sv =====
// Top level of the linear policy action selector: controller plus datapath.
// Depends on lpas_pkg, lpas_ctrl, lpas_datapath and linear_policy_action_select_defines.svh.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (lpas_pkg::in_item_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (lpas_pkg::out_item_t)
//   cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// Weight load: written straight into the weight RAM.
// Feature element: weights read and accumulated one action at a time, next element accepted only after; one shared MAC.
// Last element adds a sequential argmax and tie-break pass.
// Result sits in an output register; a stalled output holds the block only at the next result.
// Reset clears control state, loads register reset values and seeds the LFSR with 1.
`default_nettype none
`include "linear_policy_action_select_defines.svh"
module linear_policy_action_select (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire lpas_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output lpas_pkg::out_item_t                  out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [lpas_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [lpas_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lpas_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [4:0] cmd_vec;

  assign cfg_ready_o = 1'b1;

  lpas_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lpas_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  assign cmd_vec = {cmd.weight_we, cmd.mac_issue, cmd.sel_init, cmd.sel_step, cmd.emit};

  `LPAS_ASSERT(a_cmd_exclusive, clk_i, rst_ni, $onehot0(cmd_vec))
  `LPAS_ASSERT(a_ready_when_drained, clk_i, rst_ni, in_ready_o |-> status.pipe_empty)
  `LPAS_ASSERT_NEXT(a_emit_shows_result, clk_i, rst_ni, cmd.emit, out_valid_o)

endmodule
`default_nettype wire
